/* hw/rtl/oust_pkg.sv */
// Shared constants and operation codes for the ordered unique set table.
`default_nettype none

package oust_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SUIT_W   = 3;
    localparam int NUM_W    = 4;
    localparam int CARD_W   = SUIT_W + NUM_W;
    localparam int POS_W    = 6;
    localparam int RAND_W   = 16;
    localparam int STEP_W   = $clog2(RAND_W);
    localparam int MODE_W   = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT      = 3'd0,
        MODE_REMOVE_CARD = 3'd1,
        MODE_REMOVE_NUM  = 3'd2,
        MODE_PICKUP      = 3'd3,
        MODE_LOCATE_CARD = 3'd4,
        MODE_LOCATE_NUM  = 3'd5
    } mode_t;

endpackage

`default_nettype wire

/* hw/rtl/ordered_unique_set_table_core.sv */
// Ordered, duplicate-free card table with a sequenced scan, divide and shift engine.
//
// Usage: drive mode and the card/position/random fields and raise start while
// busy is low; that request is taken at the clock edge. busy stays high while
// the operation runs and no further request is taken. The result appears on
// failed, found, found_index, picked_suit, picked_number and entry_count,
// marked by done for exactly one cycle; the receiver cannot stall, so it must
// capture the result in that cycle. busy is already low in the done cycle.
// The table memory has one write and one registered read port and is walked one entry per cycle:
//   insert, remove, locate: a scan of the entries below the count,
//   remove then shifts the entries above the removed one down by one place,
//   pickup: a bit-serial modulo of the source by the count, then the same shift,
//   unknown modes and pickup from an empty table: done with no scan.
// Reset clears the entry count and the sequencer; table contents are not
// cleared, since only entries below the count are ever read.
`default_nettype none

module ordered_unique_set_table_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [oust_pkg::MODE_W-1:0]     mode,
    input  wire logic [oust_pkg::SUIT_W-1:0]     card_suit,
    input  wire logic [oust_pkg::NUM_W-1:0]      card_number,
    input  wire logic [oust_pkg::POS_W-1:0]      position,
    input  wire logic                            pick_random,
    input  wire logic [oust_pkg::RAND_W-1:0]     random_value,
    output logic                                 done,
    output logic                                 failed,
    output logic                                 found,
    output logic [oust_pkg::IDX_W-1:0]           found_index,
    output logic [oust_pkg::SUIT_W-1:0]          picked_suit,
    output logic [oust_pkg::NUM_W-1:0]           picked_number,
    output logic [oust_pkg::CNT_W-1:0]           entry_count
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_SHIFT
    } state_t;

    state_t                          state_reg, state_next;
    logic [oust_pkg::MODE_W-1:0]     mode_reg, mode_next;
    logic [oust_pkg::CARD_W-1:0]     key_reg, key_next;
    logic [oust_pkg::RAND_W-1:0]     src_reg, src_next;
    logic [oust_pkg::CNT_W-1:0]      issue_reg, issue_next;
    logic                            rd_vld_reg, rd_vld_next;
    logic [oust_pkg::IDX_W-1:0]      rd_idx_reg, rd_idx_next;
    logic [oust_pkg::IDX_W-1:0]      hit_reg, hit_next;
    logic [oust_pkg::CNT_W-1:0]      rem_reg, rem_next;
    logic [oust_pkg::STEP_W-1:0]     step_reg, step_next;
    logic [oust_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [oust_pkg::CARD_W-1:0]     pick_reg, pick_next;

    logic                            done_reg, done_next;
    logic                            failed_reg, failed_next;
    logic                            found_reg, found_next;
    logic [oust_pkg::IDX_W-1:0]      found_index_reg, found_index_next;
    logic [oust_pkg::SUIT_W-1:0]     picked_suit_reg, picked_suit_next;
    logic [oust_pkg::NUM_W-1:0]      picked_number_reg, picked_number_next;

    // table memory: one write and one registered read per cycle
    logic [oust_pkg::CARD_W-1:0]     card_mem [oust_pkg::CAPACITY];
    logic [oust_pkg::CARD_W-1:0]     rd_data_reg;
    logic                            mem_re;
    logic [oust_pkg::IDX_W-1:0]      mem_raddr;
    logic                            mem_we;
    logic [oust_pkg::IDX_W-1:0]      mem_waddr;
    logic [oust_pkg::CARD_W-1:0]     mem_wdata;

    logic                            accept;
    logic                            num_only;
    logic                            match;
    logic                            more;
    logic [oust_pkg::CNT_W:0]        div_trial;
    logic                            div_ge;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            card_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= card_mem[mem_raddr];
        end
    end

    assign accept   = start && (state_reg == ST_IDLE);
    assign num_only = (mode_reg == oust_pkg::MODE_REMOVE_NUM)
                   || (mode_reg == oust_pkg::MODE_LOCATE_NUM);
    assign match    = rd_vld_reg && (num_only
                      ? (rd_data_reg[oust_pkg::NUM_W-1:0] == key_reg[oust_pkg::NUM_W-1:0])
                      : (rd_data_reg == key_reg));
    assign more     = issue_reg < count_reg;

    // one restoring step of src mod count
    assign div_trial = {rem_reg, src_reg[oust_pkg::RAND_W-1]};
    assign div_ge    = div_trial >= {1'b0, count_reg};

    always_comb
    begin
        state_next         = state_reg;
        mode_next          = mode_reg;
        key_next           = key_reg;
        src_next           = src_reg;
        issue_next         = issue_reg;
        rd_vld_next        = 1'b0;
        rd_idx_next        = rd_idx_reg;
        hit_next           = hit_reg;
        rem_next           = rem_reg;
        step_next          = step_reg;
        count_next         = count_reg;
        pick_next          = pick_reg;
        done_next          = 1'b0;
        failed_next        = failed_reg;
        found_next         = found_reg;
        found_index_next   = found_index_reg;
        picked_suit_next   = picked_suit_reg;
        picked_number_next = picked_number_reg;
        mem_re             = 1'b0;
        mem_raddr          = issue_reg[oust_pkg::IDX_W-1:0];
        mem_we             = 1'b0;
        mem_waddr          = rd_idx_reg - oust_pkg::IDX_W'(1);
        mem_wdata          = rd_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next          = mode;
                    key_next           = {card_suit, card_number};
                    src_next           = pick_random ? random_value
                                                     : oust_pkg::RAND_W'(position);
                    issue_next         = '0;
                    rem_next           = '0;
                    step_next          = '0;
                    failed_next        = 1'b1;
                    found_next         = 1'b0;
                    found_index_next   = '0;
                    picked_suit_next   = '0;
                    picked_number_next = '0;
                    unique case (mode)
                        oust_pkg::MODE_INSERT,
                        oust_pkg::MODE_REMOVE_CARD,
                        oust_pkg::MODE_REMOVE_NUM,
                        oust_pkg::MODE_LOCATE_CARD:
                        begin
                            state_next = ST_SCAN;
                        end
                        oust_pkg::MODE_LOCATE_NUM:
                        begin
                            issue_next = oust_pkg::CNT_W'(position);
                            state_next = ST_SCAN;
                        end
                        oust_pkg::MODE_PICKUP:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_DIV;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // keep one read in flight ahead of the compare
                if (!match && more)
                begin
                    mem_re      = 1'b1;
                    rd_vld_next = 1'b1;
                    rd_idx_next = issue_reg[oust_pkg::IDX_W-1:0];
                    issue_next  = issue_reg + oust_pkg::CNT_W'(1);
                end
                if (match)
                begin
                    hit_next = rd_idx_reg;
                    priority case (mode_reg)
                        oust_pkg::MODE_REMOVE_CARD,
                        oust_pkg::MODE_REMOVE_NUM:
                        begin
                            issue_next  = oust_pkg::CNT_W'(rd_idx_reg);
                            rd_vld_next = 1'b0;
                            state_next  = ST_SHIFT;
                        end
                        oust_pkg::MODE_LOCATE_CARD,
                        oust_pkg::MODE_LOCATE_NUM:
                        begin
                            failed_next      = 1'b0;
                            found_next       = 1'b1;
                            found_index_next = rd_idx_reg;
                            done_next        = 1'b1;
                            state_next       = ST_IDLE;
                        end
                        default:
                        begin
                            // duplicate on insert
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    endcase
                end
                else if (!rd_vld_reg && !more)
                begin
                    if ((mode_reg == oust_pkg::MODE_INSERT)
                        && (count_reg < oust_pkg::CNT_W'(oust_pkg::CAPACITY)))
                    begin
                        mem_we      = 1'b1;
                        mem_waddr   = count_reg[oust_pkg::IDX_W-1:0];
                        mem_wdata   = key_reg;
                        count_next  = count_reg + oust_pkg::CNT_W'(1);
                        failed_next = 1'b0;
                    end
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_DIV:
            begin
                rem_next  = div_ge ? oust_pkg::CNT_W'(div_trial - {1'b0, count_reg})
                                   : oust_pkg::CNT_W'(div_trial);
                src_next  = src_reg << 1;
                step_next = step_reg + oust_pkg::STEP_W'(1);
                if (step_reg == oust_pkg::STEP_W'(oust_pkg::RAND_W - 1))
                begin
                    hit_next   = rem_next[oust_pkg::IDX_W-1:0];
                    issue_next = rem_next;
                    state_next = ST_SHIFT;
                end
            end

            ST_SHIFT:
            begin
                // read entry i, write it back at i - 1; the first read is the removed entry
                if (more)
                begin
                    mem_re      = 1'b1;
                    rd_vld_next = 1'b1;
                    rd_idx_next = issue_reg[oust_pkg::IDX_W-1:0];
                    issue_next  = issue_reg + oust_pkg::CNT_W'(1);
                end
                if (rd_vld_reg)
                begin
                    if (rd_idx_reg == hit_reg)
                    begin
                        pick_next = rd_data_reg;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                    end
                end
                else if (!more)
                begin
                    count_next       = count_reg - oust_pkg::CNT_W'(1);
                    failed_next      = 1'b0;
                    found_index_next = hit_reg;
                    if (mode_reg == oust_pkg::MODE_PICKUP)
                    begin
                        picked_suit_next   = pick_reg[oust_pkg::CARD_W-1:oust_pkg::NUM_W];
                        picked_number_next = pick_reg[oust_pkg::NUM_W-1:0];
                    end
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            count_reg         <= '0;
            rd_vld_reg        <= 1'b0;
            done_reg          <= 1'b0;
            mode_reg          <= '0;
            key_reg           <= '0;
            src_reg           <= '0;
            issue_reg         <= '0;
            rd_idx_reg        <= '0;
            hit_reg           <= '0;
            rem_reg           <= '0;
            step_reg          <= '0;
            pick_reg          <= '0;
            failed_reg        <= 1'b0;
            found_reg         <= 1'b0;
            found_index_reg   <= '0;
            picked_suit_reg   <= '0;
            picked_number_reg <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            count_reg         <= count_next;
            rd_vld_reg        <= rd_vld_next;
            done_reg          <= done_next;
            mode_reg          <= mode_next;
            key_reg           <= key_next;
            src_reg           <= src_next;
            issue_reg         <= issue_next;
            rd_idx_reg        <= rd_idx_next;
            hit_reg           <= hit_next;
            rem_reg           <= rem_next;
            step_reg          <= step_next;
            pick_reg          <= pick_next;
            failed_reg        <= failed_next;
            found_reg         <= found_next;
            found_index_reg   <= found_index_next;
            picked_suit_reg   <= picked_suit_next;
            picked_number_reg <= picked_number_next;
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign failed        = failed_reg;
    assign found         = found_reg;
    assign found_index   = found_index_reg;
    assign picked_suit   = picked_suit_reg;
    assign picked_number = picked_number_reg;
    assign entry_count   = count_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy)
        else $error("result strobe while sequencer busy");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= oust_pkg::CNT_W'(oust_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (oust_pkg::CNT_W'(rd_idx_reg) < count_reg))
        else $error("table read beyond entry count");

    a_count_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> done_reg)
        else $error("entry count changed without a result");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done_reg))
        else $error("request accepted but neither busy nor done");

endmodule

`default_nettype wire
